// File: rtl/core/ptsg_pkg.sv
// ----------------------------------------------------------------------------
// ptsg_pkg
// Shared types, codes and constants of the pan/tilt servo command gate.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsg_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_WIDTH = 32;
  localparam int PULSE_WIDTH = 16;
  localparam int ADDR_WIDTH  = 5;
  localparam int DATA_WIDTH  = 32;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [TOTAL_WIDTH-1:0] total_t;
  typedef logic [PULSE_WIDTH-1:0] pulse_t;

  localparam cnt_t CNT_ONE = cnt_t'(1);

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_ENABLE  = 2'd1,
    MODE_APPLY   = 2'd2,
    MODE_DISABLE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_PAN_SAFE_MIN   = 3'd0,
    REG_PAN_SAFE_MAX   = 3'd1,
    REG_TILT_SAFE_MIN  = 3'd2,
    REG_TILT_SAFE_MAX  = 3'd3,
    REG_ELECTRICAL_MIN = 3'd4,
    REG_ELECTRICAL_MAX = 3'd5,
    REG_PAN_CENTER     = 3'd6,
    REG_TILT_CENTER    = 3'd7
  } reg_index_t;

  localparam pulse_t PAN_SAFE_MIN_RST   = 16'd1000;
  localparam pulse_t PAN_SAFE_MAX_RST   = 16'd2000;
  localparam pulse_t TILT_SAFE_MIN_RST  = 16'd1000;
  localparam pulse_t TILT_SAFE_MAX_RST  = 16'd2000;
  localparam pulse_t ELECTRICAL_MIN_RST = 16'd500;
  localparam pulse_t ELECTRICAL_MAX_RST = 16'd2500;
  localparam pulse_t PAN_CENTER_RST     = 16'd1500;
  localparam pulse_t TILT_CENTER_RST    = 16'd1500;

  typedef struct packed {
    pulse_t pan_safe_min;
    pulse_t pan_safe_max;
    pulse_t tilt_safe_min;
    pulse_t tilt_safe_max;
    pulse_t electrical_min;
    pulse_t electrical_max;
    pulse_t pan_center;
    pulse_t tilt_center;
  } cfg_t;

  typedef struct packed {
    logic   ok;
    pulse_t applied_pan;
    pulse_t applied_tilt;
    logic   pan_limited;
    logic   tilt_limited;
    logic   enabled_now;
    total_t command_total;
    total_t pan_saturation_total;
    total_t tilt_saturation_total;
    total_t fault_total;
    total_t enable_total;
    total_t disable_total;
  } res_t;

  // Zero-extend or truncate a counter to the reported width.
  function automatic total_t to_total(input cnt_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[TOTAL_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptsg_regs.sv
// ----------------------------------------------------------------------------
// ptsg_regs
// APB register file holding the safe windows, electrical window and centers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ptsg_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [ptsg_pkg::DATA_WIDTH-1:0] pwdata,
  output logic      [ptsg_pkg::DATA_WIDTH-1:0] prdata,
  output logic                             pready,
  output ptsg_pkg::cfg_t                   cfg
);
  import ptsg_pkg::*;

  reg_index_t idx;
  pulse_t     wval;
  pulse_t     rval;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[ADDR_WIDTH-1:2]);
  assign wval   = pwdata[PULSE_WIDTH-1:0];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_safe_min   <= PAN_SAFE_MIN_RST;
      cfg.pan_safe_max   <= PAN_SAFE_MAX_RST;
      cfg.tilt_safe_min  <= TILT_SAFE_MIN_RST;
      cfg.tilt_safe_max  <= TILT_SAFE_MAX_RST;
      cfg.electrical_min <= ELECTRICAL_MIN_RST;
      cfg.electrical_max <= ELECTRICAL_MAX_RST;
      cfg.pan_center     <= PAN_CENTER_RST;
      cfg.tilt_center    <= TILT_CENTER_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PAN_SAFE_MIN:   cfg.pan_safe_min   <= wval;
        REG_PAN_SAFE_MAX:   cfg.pan_safe_max   <= wval;
        REG_TILT_SAFE_MIN:  cfg.tilt_safe_min  <= wval;
        REG_TILT_SAFE_MAX:  cfg.tilt_safe_max  <= wval;
        REG_ELECTRICAL_MIN: cfg.electrical_min <= wval;
        REG_ELECTRICAL_MAX: cfg.electrical_max <= wval;
        REG_PAN_CENTER:     cfg.pan_center     <= wval;
        REG_TILT_CENTER:    cfg.tilt_center    <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PAN_SAFE_MIN:   rval = cfg.pan_safe_min;
      REG_PAN_SAFE_MAX:   rval = cfg.pan_safe_max;
      REG_TILT_SAFE_MIN:  rval = cfg.tilt_safe_min;
      REG_TILT_SAFE_MAX:  rval = cfg.tilt_safe_max;
      REG_ELECTRICAL_MIN: rval = cfg.electrical_min;
      REG_ELECTRICAL_MAX: rval = cfg.electrical_max;
      REG_PAN_CENTER:     rval = cfg.pan_center;
      REG_TILT_CENTER:    rval = cfg.tilt_center;
      default:            rval = '0;
    endcase
  end

  assign prdata = DATA_WIDTH'(rval);

endmodule

`default_nettype wire

// File: rtl/core/ptsg_eval.sv
// ----------------------------------------------------------------------------
// ptsg_eval
// Gate state (flags and counters) and the combinational evaluation of one
// command against it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptsg_eval (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic [1:0]                       mode,
  input  wire logic [ptsg_pkg::PULSE_WIDTH-1:0] pan_request,
  input  wire logic [ptsg_pkg::PULSE_WIDTH-1:0] tilt_request,
  input  wire ptsg_pkg::cfg_t                   cfg,
  output ptsg_pkg::res_t                        res
);
  import ptsg_pkg::*;

  logic initialized;
  logic enabled;
  cnt_t command_cnt, pan_sat_cnt, tilt_sat_cnt, fault_cnt, enable_cnt, disable_cnt;

  logic initialized_next;
  logic enabled_next;
  cnt_t command_cnt_next, pan_sat_cnt_next, tilt_sat_cnt_next;
  cnt_t fault_cnt_next, enable_cnt_next, disable_cnt_next;

  logic   pan_lo, pan_hi, tilt_lo, tilt_hi;
  pulse_t pan_clamped, tilt_clamped;
  logic   pan_elec_ok, tilt_elec_ok;
  logic   centers_ok;
  logic   ok;
  logic   psat, tsat;
  pulse_t apan, atilt;

  // Signed request against unsigned window bound, both widened by one bit.
  assign pan_lo  = $signed({pan_request[PULSE_WIDTH-1], pan_request})
                   < $signed({1'b0, cfg.pan_safe_min});
  assign pan_hi  = $signed({pan_request[PULSE_WIDTH-1], pan_request})
                   > $signed({1'b0, cfg.pan_safe_max});
  assign tilt_lo = $signed({tilt_request[PULSE_WIDTH-1], tilt_request})
                   < $signed({1'b0, cfg.tilt_safe_min});
  assign tilt_hi = $signed({tilt_request[PULSE_WIDTH-1], tilt_request})
                   > $signed({1'b0, cfg.tilt_safe_max});

  // Low bound wins on an inverted window.
  assign pan_clamped  = pan_lo  ? cfg.pan_safe_min  :
                        pan_hi  ? cfg.pan_safe_max  : pan_request;
  assign tilt_clamped = tilt_lo ? cfg.tilt_safe_min :
                        tilt_hi ? cfg.tilt_safe_max : tilt_request;

  assign pan_elec_ok  = (pan_clamped >= cfg.electrical_min)
                        && (pan_clamped <= cfg.electrical_max);
  assign tilt_elec_ok = (tilt_clamped >= cfg.electrical_min)
                        && (tilt_clamped <= cfg.electrical_max);
  assign centers_ok   = (cfg.pan_center >= cfg.electrical_min)
                        && (cfg.pan_center <= cfg.electrical_max)
                        && (cfg.tilt_center >= cfg.electrical_min)
                        && (cfg.tilt_center <= cfg.electrical_max);

  always_comb begin
    initialized_next  = initialized;
    enabled_next      = enabled;
    command_cnt_next  = command_cnt;
    pan_sat_cnt_next  = pan_sat_cnt;
    tilt_sat_cnt_next = tilt_sat_cnt;
    fault_cnt_next    = fault_cnt;
    enable_cnt_next   = enable_cnt;
    disable_cnt_next  = disable_cnt;
    ok    = 1'b0;
    psat  = 1'b0;
    tsat  = 1'b0;
    apan  = '0;
    atilt = '0;
    case (mode_t'(mode))
      MODE_INIT: begin
        command_cnt_next  = '0;
        pan_sat_cnt_next  = '0;
        tilt_sat_cnt_next = '0;
        fault_cnt_next    = '0;
        enable_cnt_next   = '0;
        disable_cnt_next  = '0;
        initialized_next  = 1'b1;
        enabled_next      = 1'b0;
        ok                = 1'b1;
      end
      MODE_ENABLE: begin
        if (initialized) begin
          if (centers_ok) begin
            enabled_next    = 1'b1;
            enable_cnt_next = enable_cnt + CNT_ONE;
            ok              = 1'b1;
          end else begin
            if (enabled) disable_cnt_next = disable_cnt + CNT_ONE;
            enabled_next   = 1'b0;
            fault_cnt_next = fault_cnt + CNT_ONE;
          end
        end
      end
      MODE_APPLY: begin
        if (initialized && enabled) begin
          psat = pan_lo || pan_hi;
          tsat = tilt_lo || tilt_hi;
          if (pan_elec_ok && tilt_elec_ok) begin
            command_cnt_next = command_cnt + CNT_ONE;
            if (psat) pan_sat_cnt_next = pan_sat_cnt + CNT_ONE;
            if (tsat) tilt_sat_cnt_next = tilt_sat_cnt + CNT_ONE;
            apan  = pan_clamped;
            atilt = tilt_clamped;
            ok    = 1'b1;
          end else begin
            // Fault out of the enabled state.
            disable_cnt_next = disable_cnt + CNT_ONE;
            enabled_next     = 1'b0;
            fault_cnt_next   = fault_cnt + CNT_ONE;
          end
        end
      end
      MODE_DISABLE: begin
        if (enabled) disable_cnt_next = disable_cnt + CNT_ONE;
        enabled_next = 1'b0;
        ok           = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initialized  <= 1'b0;
      enabled      <= 1'b0;
      command_cnt  <= '0;
      pan_sat_cnt  <= '0;
      tilt_sat_cnt <= '0;
      fault_cnt    <= '0;
      enable_cnt   <= '0;
      disable_cnt  <= '0;
    end else if (step) begin
      initialized  <= initialized_next;
      enabled      <= enabled_next;
      command_cnt  <= command_cnt_next;
      pan_sat_cnt  <= pan_sat_cnt_next;
      tilt_sat_cnt <= tilt_sat_cnt_next;
      fault_cnt    <= fault_cnt_next;
      enable_cnt   <= enable_cnt_next;
      disable_cnt  <= disable_cnt_next;
    end
  end

  always_comb begin
    res.ok                    = ok;
    res.applied_pan           = apan;
    res.applied_tilt          = atilt;
    res.pan_limited           = psat;
    res.tilt_limited          = tsat;
    res.enabled_now           = enabled_next;
    res.command_total         = to_total(command_cnt_next);
    res.pan_saturation_total  = to_total(pan_sat_cnt_next);
    res.tilt_saturation_total = to_total(tilt_sat_cnt_next);
    res.fault_total           = to_total(fault_cnt_next);
    res.enable_total          = to_total(enable_cnt_next);
    res.disable_total         = to_total(disable_cnt_next);
  end

endmodule

`default_nettype wire

// File: rtl/core/pan_tilt_servo_command_gate.sv
// ----------------------------------------------------------------------------
// pan_tilt_servo_command_gate
// Gates pan/tilt servo pulse commands: init, enable, apply and disable.
// ----------------------------------------------------------------------------
// Path: a command is captured in the input register, then evaluated into the
//   result register.
// Throughput: one command per cycle while res_stall is low; state updates as
//   each command enters the result register, so the next sees it without bubbles.
// Reset: clears flags, counters and both pipeline valids; configuration
//   registers return to their default windows and centers.
`default_nettype none

module pan_tilt_servo_command_gate (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ptsg_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic [ptsg_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic      [ptsg_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                                  pready,
  // command channel
  input  wire logic                             cmd_valid,
  output logic                                  cmd_stall,
  input  wire logic [1:0]                       mode,
  input  wire logic [ptsg_pkg::PULSE_WIDTH-1:0] pan_request,
  input  wire logic [ptsg_pkg::PULSE_WIDTH-1:0] tilt_request,
  // result channel
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output logic                                  ok,
  output logic      [ptsg_pkg::PULSE_WIDTH-1:0] applied_pan,
  output logic      [ptsg_pkg::PULSE_WIDTH-1:0] applied_tilt,
  output logic                                  pan_limited,
  output logic                                  tilt_limited,
  output logic                                  enabled_now,
  output logic      [ptsg_pkg::TOTAL_WIDTH-1:0] command_total,
  output logic      [ptsg_pkg::TOTAL_WIDTH-1:0] pan_saturation_total,
  output logic      [ptsg_pkg::TOTAL_WIDTH-1:0] tilt_saturation_total,
  output logic      [ptsg_pkg::TOTAL_WIDTH-1:0] fault_total,
  output logic      [ptsg_pkg::TOTAL_WIDTH-1:0] enable_total,
  output logic      [ptsg_pkg::TOTAL_WIDTH-1:0] disable_total
);
  import ptsg_pkg::*;

  cfg_t cfg;

  // input register
  logic       in_full;
  logic [1:0] in_mode;
  pulse_t     in_pan;
  pulse_t     in_tilt;

  // result register
  logic out_full;
  res_t out_res;
  res_t eval_res;

  logic out_load;
  logic in_load;

  ptsg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance a held command into the result register whenever it is empty or being drained.
  assign out_load  = in_full && (!out_full || !res_stall);
  assign in_load   = cmd_valid && !cmd_stall;
  assign cmd_stall = in_full && !out_load;

  ptsg_eval u_eval (
    .clk          (clk),
    .rst          (rst),
    .step         (out_load),
    .mode         (in_mode),
    .pan_request  (in_pan),
    .tilt_request (in_tilt),
    .cfg          (cfg),
    .res          (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_load || out_load) begin
      in_full <= in_load;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_mode <= mode;
      in_pan  <= pan_request;
      in_tilt <= tilt_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (!res_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= eval_res;
    end
  end

  assign res_valid             = out_full;
  assign ok                    = out_res.ok;
  assign applied_pan           = out_res.applied_pan;
  assign applied_tilt          = out_res.applied_tilt;
  assign pan_limited           = out_res.pan_limited;
  assign tilt_limited          = out_res.tilt_limited;
  assign enabled_now           = out_res.enabled_now;
  assign command_total         = out_res.command_total;
  assign pan_saturation_total  = out_res.pan_saturation_total;
  assign tilt_saturation_total = out_res.tilt_saturation_total;
  assign fault_total           = out_res.fault_total;
  assign enable_total          = out_res.enable_total;
  assign disable_total         = out_res.disable_total;

endmodule

`default_nettype wire
